FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/tccc_pkg.sv
// Shared types and constants of the text console caret control unit.
`default_nettype none
package tccc_pkg;

  localparam int CharW  = 8;
  localparam int RowW   = 7;
  localparam int ColW   = 8;
  localparam int ColorW = 32;
  localparam int OutW   = 72;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegTextColumns = 2'd0;
  localparam logic [1:0] RegTextRows    = 2'd1;
  localparam logic [1:0] RegFgColor     = 2'd2;

  localparam logic [ColW-1:0]   ColumnsReset = 8'd80;
  localparam logic [RowW-1:0]   RowsReset    = 7'd25;
  localparam logic [ColorW-1:0] ColorReset   = 32'hFFFF_FFFF;

  // Character codes
  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChReturn  = 8'd13;
  localparam logic [CharW-1:0] ChSpace   = 8'd32;

  localparam logic [ColW:0] TabStep = 9'd8;
  localparam logic [ColW:0] TabMask = 9'h1F8;

  typedef struct packed {
    logic [ColW-1:0]   text_columns;
    logic [RowW-1:0]   text_rows;
    logic [ColorW-1:0] foreground_color;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } caret_t;

  // Last member sits in the lowest bits.
  typedef struct packed {
    logic [ColW-1:0]   new_caret_col;
    logic [RowW-1:0]   new_caret_row;
    logic              scroll_up;
    logic [ColorW-1:0] draw_color;
    logic [CharW-1:0]  glyph_code;
    logic [ColW-1:0]   draw_col;
    logic [RowW-1:0]   draw_row;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/tccc_regs.sv
// APB-style configuration register file.
`default_nettype none
module tccc_regs
  import tccc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_columns     <= ColumnsReset;
      cfg.text_rows        <= RowsReset;
      cfg.foreground_color <= ColorReset;
    end else if (wr) begin
      unique case (idx)
        RegTextColumns: cfg.text_columns     <= pwdata[ColW-1:0];
        RegTextRows:    cfg.text_rows        <= pwdata[RowW-1:0];
        RegFgColor:     cfg.foreground_color <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTextColumns: prdata = {{(DataW-ColW){1'b0}}, cfg.text_columns};
      RegTextRows:    prdata = {{(DataW-RowW){1'b0}}, cfg.text_rows};
      RegFgColor:     prdata = cfg.foreground_color;
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/tccc_caret.sv
// Caret state and the single-pass caret update / draw command logic.
`default_nettype none
module tccc_caret
  import tccc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [CharW-1:0] char_code,
  input  wire cfg_t             cfg,
  output result_t               result,
  output caret_t                caret
);

  logic [ColW:0]   col_adv;
  logic [ColW:0]   col_wrap;
  logic [RowW:0]   row_adv;
  logic [RowW:0]   row_wrap;
  logic [RowW:0]   row_fin;
  logic [CharW-1:0] glyph;
  logic            scroll;
  logic [RowW-1:0] draw_row;

  always_comb begin
    row_adv = {1'b0, caret.row};
    glyph   = ChSpace;
    unique case (char_code)
      ChTab:     col_adv = ({1'b0, caret.col} + TabStep) & TabMask;
      ChNewline: begin
        col_adv = '0;
        row_adv = {1'b0, caret.row} + 8'd1;
      end
      ChReturn:  col_adv = '0;
      default: begin
        col_adv = {1'b0, caret.col} + 9'd1;
        glyph   = char_code;
      end
    endcase

    // single wrap by the column count
    if (col_adv >= {1'b0, cfg.text_columns}) begin
      col_wrap = col_adv - {1'b0, cfg.text_columns};
      row_wrap = row_adv + 8'd1;
    end else begin
      col_wrap = col_adv;
      row_wrap = row_adv;
    end

    // scroll steps back one row, saturating at zero
    scroll   = (row_wrap >= {1'b0, cfg.text_rows});
    row_fin  = row_wrap;
    draw_row = caret.row;
    if (scroll) begin
      if (row_wrap != '0) row_fin = row_wrap - 8'd1;
      if (caret.row != '0) draw_row = caret.row - 7'd1;
    end

    result.draw_row      = draw_row;
    result.draw_col      = caret.col;
    result.glyph_code    = glyph;
    result.draw_color    = cfg.foreground_color;
    result.scroll_up     = scroll;
    result.new_caret_row = row_fin[RowW-1:0];
    result.new_caret_col = col_wrap[ColW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caret <= '0;
    end else if (advance) begin
      caret.row <= result.new_caret_row;
      caret.col <= result.new_caret_col;
    end
  end

endmodule
`default_nettype wire

FILE: sv/text_console_caret_control_unit.sv
// Top level of the text console caret control unit.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: char_code
//  m_*       out  m_tvalid/m_tready    tdata: draw command
//  apb       in   psel/penable/pready  text_columns, text_rows, foreground_color
//
// One character word per cycle sustained while m_tready stays high; each word
// first sits in the input register, where it stays while the result register is stalled,
// and then sits in the result register until taken.
// The caret register updates as a word moves from input to result register,
// so the next word always sees the caret its predecessor left.
// rst is synchronous, active high: empties both stages, zeroes the caret and
// restores the register defaults (80 columns, 25 rows, white).
// A stall on m_tready holds the result register; the input register still
// takes one more word, then s_tready drops.
`default_nettype none
`include "assert_macros.svh"
module text_console_caret_control_unit
  import tccc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // character stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [CharW-1:0] s_tdata,   // [7:0] char_code
  // draw command stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // [6:0] draw_row, [14:7] draw_col, [22:15] glyph_code, [54:23] draw_color,
  // [55] scroll_up, [62:56] new_caret_row, [70:63] new_caret_col, [71] zero
  output logic      [OutW-1:0]  m_tdata,
  // configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t             cfg;
  result_t          result;
  caret_t           caret;

  // input register
  logic             in_valid;
  logic [CharW-1:0] in_char;
  // result register
  result_t          out_data;

  logic             move;     // word advances input -> result register

  assign move     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || move;
  assign m_tdata  = {1'b0, out_data};

  tccc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tccc_caret u_caret (
    .clk       (clk),
    .rst       (rst),
    .advance   (move),
    .char_code (in_char),
    .cfg       (cfg),
    .result    (result),
    .caret     (caret)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= result;
    end
  end

  // An empty input register never back-pressures the source.
  `ASSERT_IMPLIES(a_empty_ready, clk, rst, !in_valid, s_tready)
  // The held command's new caret always matches the live caret register.
  `ASSERT_IMPLIES(a_caret_match, clk, rst, m_tvalid,
                  (caret.row == out_data.new_caret_row) &&
                  (caret.col == out_data.new_caret_col))
  // A stalled command with a word waiting keeps the input register full.
  `ASSERT_NEXT(a_stall_hold, clk, rst, in_valid && m_tvalid && !m_tready,
               in_valid && m_tvalid)

endmodule
`default_nettype wire
